// ----- sv/dtps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dtps_pkg;

  // fixed field widths
  localparam int unsigned CoordW  = 9;
  localparam int unsigned DepthW  = 32;
  localparam int unsigned ChanW   = 10;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgW    = 9;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned ModeW   = 2;

  // item modes
  localparam logic [ModeW-1:0] MODE_FRAG  = 2'd0;
  localparam logic [ModeW-1:0] MODE_CLEAR = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ  = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CfgW-1:0] FRAME_DIM_RESET = 9'd256;

  // depth of a cleared pixel
  localparam logic [DepthW-1:0] FAR_DEPTH = 32'h7FFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic clr_step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_clear;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/dtps_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtps_ctrl
  import dtps_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire  logic out_ready_i,
  output cmd_t       cmd_o,
  input  wire  sts_t sts_i
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CLEAR  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = sts_i.is_clear ? S_CLEAR : S_DECIDE;
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- sv/dtps_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtps_datapath
  import dtps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  input  wire  cmd_t                      cmd_i,
  output sts_t                            sts_o,
  input  wire  logic                      cfg_we_i,
  input  wire  logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire  logic [CfgW-1:0]           cfg_data_i,
  input  wire  logic [ModeW-1:0]          mode_i,
  input  wire  logic [CoordW-1:0]         x_coord_i,
  input  wire  logic [CoordW-1:0]         y_coord_i,
  input  wire  logic signed [DepthW-1:0]  frag_depth_i,
  input  wire  logic signed [ChanW-1:0]   red_in_i,
  input  wire  logic signed [ChanW-1:0]   green_in_i,
  input  wire  logic signed [ChanW-1:0]   blue_in_i,
  output logic                            coord_valid_o,
  output logic                            was_written_o,
  output logic [ByteW-1:0]                red_out_o,
  output logic [ByteW-1:0]                green_out_o,
  output logic [ByteW-1:0]                blue_out_o,
  output logic signed [DepthW-1:0]        depth_out_o
);

  localparam int unsigned StoreSize = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW     = (StoreSize > 1) ? $clog2(StoreSize) : 1;
  localparam int unsigned MaxDim    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DimW      = ($clog2(MaxDim + 1) > CfgW) ? $clog2(MaxDim + 1) : CfgW;
  localparam int unsigned ProdW     = CoordW + DimW;
  localparam int unsigned ColorW    = 3 * ByteW;
  localparam int unsigned EntryW    = ColorW + DepthW;

  // (c*255 + 65280) >> 9, saturated to a byte
  function automatic logic [ByteW-1:0] to_byte(logic signed [ChanW-1:0] c);
    logic signed [19:0] sum;
    logic [10:0]        shifted;
    sum     = (20'(c) <<< 8) - 20'(c) + 20'sd65280;
    shifted = sum[19:9];
    if (sum < 0) begin
      return '0;
    end else if (shifted > 11'd255) begin
      return 8'hFF;
    end
    return shifted[ByteW-1:0];
  endfunction

  // configuration
  logic [CfgW-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_DIM_RESET;
      frame_height_q <= FRAME_DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
      endcase
    end
  end

  // address generation
  logic [DimW-1:0]  w_eff, h_eff;
  logic             coord_ok;
  logic [ProdW-1:0] idx_full;

  always_comb begin
    w_eff = (32'(frame_width_q) > 32'(MAX_WIDTH)) ? DimW'(MAX_WIDTH) : DimW'(frame_width_q);
    h_eff = (32'(frame_height_q) > 32'(MAX_HEIGHT)) ? DimW'(MAX_HEIGHT)
                                                     : DimW'(frame_height_q);
    coord_ok = (DimW'(x_coord_i) < w_eff) && (DimW'(y_coord_i) < h_eff);
    idx_full = ProdW'(y_coord_i) * ProdW'(w_eff) + ProdW'(x_coord_i);
  end

  // item registers
  logic [ModeW-1:0]         mode_q;
  logic                     valid_q;
  logic [AddrW-1:0]         idx_q;
  logic signed [DepthW-1:0] depth_q;
  logic [ColorW-1:0]        color_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      valid_q <= coord_ok;
      idx_q   <= AddrW'(idx_full);
      depth_q <= frag_depth_i;
      color_q <= {to_byte(red_in_i), to_byte(green_in_i), to_byte(blue_in_i)};
    end
  end

  // clear sweep
  logic [AddrW-1:0] clr_addr_q;
  logic             clr_last;

  assign clr_last = (clr_addr_q == AddrW'(StoreSize - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_addr_q <= clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  // pixel memory: {color, depth}
  logic [EntryW-1:0]        mem [StoreSize];
  logic [EntryW-1:0]        rdata_q;
  logic signed [DepthW-1:0] rd_depth;
  logic                     pass;
  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [EntryW-1:0]        mem_wdata;

  assign rd_depth = rdata_q[DepthW-1:0];
  assign pass     = (mode_q == MODE_FRAG) && valid_q && (depth_q < rd_depth);

  always_comb begin
    if (cmd_i.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = {{ColorW{1'b0}}, FAR_DEPTH};
    end else begin
      mem_we    = cmd_i.commit && pass;
      mem_waddr = idx_q;
      mem_wdata = {color_q, depth_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[idx_q];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      coord_valid_o <= valid_q;
      was_written_o <= pass;
      if (!valid_q) begin
        {red_out_o, green_out_o, blue_out_o} <= '0;
        depth_out_o                          <= '0;
      end else if (mode_q == MODE_CLEAR) begin
        {red_out_o, green_out_o, blue_out_o} <= '0;
        depth_out_o                          <= FAR_DEPTH;
      end else if (pass) begin
        {red_out_o, green_out_o, blue_out_o} <= color_q;
        depth_out_o                          <= depth_q;
      end else begin
        {red_out_o, green_out_o, blue_out_o} <= rdata_q[EntryW-1:DepthW];
        depth_out_o                          <= rd_depth;
      end
    end
  end

  assign sts_o.is_clear = (mode_q == MODE_CLEAR);
  assign sts_o.clr_last = clr_last;

endmodule

`default_nettype wire

// ----- sv/depth_tested_pixel_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

// depth-tested pixel store: a frame of MAX_WIDTH x MAX_HEIGHT pixels, each holding an rgb
// byte triple and a signed 32-bit depth, kept in a single-port-write memory. every input
// transaction yields exactly one output transaction that shows the pixel at (x, y) after
// the step. a fragment (mode 0) inside the frame is stored when its depth is strictly less
// than the stored one, its channels converted by (c*255+65280)>>9 and clamped to 0..255; a
// clear (mode 1) sweeps the whole memory; a read (mode 2, and the unused mode 3) only
// looks. coordinates outside the frame answer with all fields zero. fragment and read hold
// the block through accept, memory read, and compare and write-back, steps set by the
// read-then-write of the same memory entry; a clear adds a sweep of the whole memory, one
// entry per cycle, between memory read and compare and write-back. a result not yet taken
// holds the write-back, which stretches the item. after reset the same sweep runs over the
// whole memory with in_ready_o low; configuration writes are taken at any time but are
// meant to happen only while the block is idle. frame_width and frame_height saturate at
// MAX_WIDTH and MAX_HEIGHT.

module depth_tested_pixel_store
  import dtps_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire  logic                      clk_i,
  input  wire  logic                      rst_ni,
  // configuration
  input  wire  logic                      cfg_we_i,
  input  wire  logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire  logic [CfgW-1:0]           cfg_data_i,
  // input transactions
  input  wire  logic                      in_valid_i,
  output logic                            in_ready_o,
  input  wire  logic [ModeW-1:0]          mode_i,
  input  wire  logic [CoordW-1:0]         x_coord_i,
  input  wire  logic [CoordW-1:0]         y_coord_i,
  input  wire  logic signed [DepthW-1:0]  frag_depth_i,
  input  wire  logic signed [ChanW-1:0]   red_in_i,
  input  wire  logic signed [ChanW-1:0]   green_in_i,
  input  wire  logic signed [ChanW-1:0]   blue_in_i,
  // output transactions
  output logic                            out_valid_o,
  input  wire  logic                      out_ready_i,
  output logic                            coord_valid_o,
  output logic                            was_written_o,
  output logic [ByteW-1:0]                red_out_o,
  output logic [ByteW-1:0]                green_out_o,
  output logic [ByteW-1:0]                blue_out_o,
  output logic signed [DepthW-1:0]        depth_out_o
);

  cmd_t dp_cmd;
  sts_t dp_sts;

  // sequencing: reset sweep, accept, read, optional clear sweep, compare and commit
  dtps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  // frame size registers, address math, pixel memory, depth test and result register
  dtps_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .frag_depth_i  (frag_depth_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .coord_valid_o (coord_valid_o),
    .was_written_o (was_written_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .depth_out_o   (depth_out_o)
  );

  // one transaction in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a transaction while one is in flight");

  // a commit never overwrites a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.commit |-> !(out_valid_o && !out_ready_i))
    else $error("result register overwritten");

  // no acceptance during a clear sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.clr_step |-> !in_ready_o)
    else $error("input ready during clear sweep");

  // only an in-frame pixel can be written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_written_o |-> coord_valid_o)
    else $error("write reported for out-of-frame coordinate");

endmodule

`default_nettype wire

// ----- tb/depth_tested_pixel_store_tb.sv -----
`timescale 1ns / 1ps

module depth_tested_pixel_store_tb;
  import dtps_pkg::*;

  localparam int unsigned MAX_W       = 256;
  localparam int unsigned MAX_H       = 256;
  localparam int unsigned STORE_DEPTH = MAX_W * MAX_H;
  // reset sweep plus a handful of clears, each one entry per cycle, taken several times over
  localparam int unsigned CYCLE_LIMIT = 2_500_000;
  // spare mode, answered like a read
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;

  // one input transaction
  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [DepthW-1:0] depth;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
  } pixel_req_t;

  // one output transaction
  typedef struct packed {
    logic              coord_valid;
    logic              was_written;
    logic [ByteW-1:0]  red;
    logic [ByteW-1:0]  green;
    logic [ByteW-1:0]  blue;
    logic [DepthW-1:0] depth;
  } pixel_resp_t;

  // dut ports, the inputs all known from time zero
  logic                      clk_i        = 1'b0;
  logic                      rst_ni       = 1'b0;
  logic                      cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i  = '0;
  logic [CfgW-1:0]           cfg_data_i   = '0;
  logic                      in_valid_i   = 1'b0;
  logic                      in_ready_o;
  logic [ModeW-1:0]          mode_i       = '0;
  logic [CoordW-1:0]         x_coord_i    = '0;
  logic [CoordW-1:0]         y_coord_i    = '0;
  logic signed [DepthW-1:0]  frag_depth_i = '0;
  logic signed [ChanW-1:0]   red_in_i     = '0;
  logic signed [ChanW-1:0]   green_in_i   = '0;
  logic signed [ChanW-1:0]   blue_in_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i  = 1'b1;
  logic                      coord_valid_o;
  logic                      was_written_o;
  logic [ByteW-1:0]          red_out_o;
  logic [ByteW-1:0]          green_out_o;
  logic [ByteW-1:0]          blue_out_o;
  logic signed [DepthW-1:0]  depth_out_o;

  // shadow frame store and frame size registers
  logic [3*ByteW-1:0] color_shadow [0:STORE_DEPTH-1];
  logic [DepthW-1:0]  depth_shadow [0:STORE_DEPTH-1];
  int unsigned        frame_w_reg;
  int unsigned        frame_h_reg;

  // pixels still owed by the dut, oldest first
  pixel_resp_t pending_pixels [$];

  int unsigned send_gap_pct     = 0;
  int unsigned recv_stall_pct   = 0;
  int unsigned ready_hold_left  = 0;
  int unsigned error_count      = 0;
  int unsigned cycle_count      = 0;

  depth_tested_pixel_store #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .frag_depth_i  (frag_depth_i),
    .red_in_i      (red_in_i),
    .green_in_i    (green_in_i),
    .blue_in_i     (blue_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coord_valid_o (coord_valid_o),
    .was_written_o (was_written_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .depth_out_o   (depth_out_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // sizes beyond the store saturate
  function automatic int unsigned width_in_use();
    return (frame_w_reg > MAX_W) ? MAX_W : frame_w_reg;
  endfunction

  function automatic int unsigned height_in_use();
    return (frame_h_reg > MAX_H) ? MAX_H : frame_h_reg;
  endfunction

  function automatic void wipe_shadow();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      color_shadow[i] = '0;
      depth_shadow[i] = FAR_DEPTH;
    end
  endfunction

  // fixed point 256 = 1.0 to a byte: (c*255 + 65280) >> 9, clamped to 0..255
  function automatic logic [ByteW-1:0] chan_to_byte(input logic [ChanW-1:0] chan);
    int sum;
    sum = $signed(chan) * 255 + 65280;
    if (sum < 0) return '0;
    if ((sum >>> 9) > 255) return 8'hFF;
    return sum[ByteW+8:9];
  endfunction

  // applies one transaction to the shadow store and gives the pixel it reports
  function automatic pixel_resp_t shade_pixel(input pixel_req_t req);
    int unsigned w_use;
    int unsigned h_use;
    int unsigned idx;
    logic        in_frame;
    pixel_resp_t px;
    w_use    = width_in_use();
    h_use    = height_in_use();
    in_frame = (req.x < w_use) && (req.y < h_use);
    idx      = in_frame ? (req.x + req.y * w_use) : 0;
    px       = '0;
    px.coord_valid = in_frame;
    if (req.mode == MODE_CLEAR) begin
      wipe_shadow();
    end else if (req.mode == MODE_FRAG && in_frame &&
                 $signed(req.depth) < $signed(depth_shadow[idx])) begin
      color_shadow[idx] = {chan_to_byte(req.red), chan_to_byte(req.green),
                           chan_to_byte(req.blue)};
      depth_shadow[idx] = req.depth;
      px.was_written    = 1'b1;
    end
    // outside the frame every field stays zero
    if (in_frame) begin
      {px.red, px.green, px.blue} = color_shadow[idx];
      px.depth = depth_shadow[idx];
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------

  // valid stays high between back-to-back transactions; it only drops on a gap,
  // before a register write and at the end
  task automatic send_pixel_req(input pixel_req_t req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= req.mode;
    x_coord_i    <= req.x;
    y_coord_i    <= req.y;
    frag_depth_i <= req.depth;
    red_in_i     <= req.red;
    green_in_i   <= req.green;
    blue_in_i    <= req.blue;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    // accepted at this edge, so the shadow moves on in transaction order
    pending_pixels.push_back(shade_pixel(req));
  endtask

  task automatic send_fields(input logic [ModeW-1:0] mode, input int x, input int y,
                             input logic [DepthW-1:0] depth, input int r, input int g,
                             input int b);
    pixel_req_t req;
    req.mode  = mode;
    req.x     = x[CoordW-1:0];
    req.y     = y[CoordW-1:0];
    req.depth = depth;
    req.red   = r[ChanW-1:0];
    req.green = g[ChanW-1:0];
    req.blue  = b[ChanW-1:0];
    send_pixel_req(req);
  endtask

  // registers change only with the block idle: every owed pixel has come back
  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= w[CfgW-1:0];
    @(posedge clk_i);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= h[CfgW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    frame_w_reg = w & 32'h1FF;
    frame_h_reg = h & 32'h1FF;
  endtask

  // mostly fragments on a few hot pixels so depth tests both pass and fail,
  // some reads, the spare mode now and then, and a share of wild coordinates
  function automatic pixel_req_t random_pixel_req();
    pixel_req_t  req;
    int unsigned roll;
    int unsigned hot_w;
    int unsigned hot_h;
    roll     = $urandom_range(99);
    req.mode = (roll < 62) ? MODE_FRAG : (roll < 92) ? MODE_READ : MODE_SPARE;
    hot_w    = (width_in_use() < 6) ? width_in_use() : 6;
    hot_h    = (height_in_use() < 4) ? height_in_use() : 4;
    roll     = $urandom_range(99);
    if (roll < 65 && hot_w != 0 && hot_h != 0) begin
      req.x = CoordW'($urandom_range(hot_w - 1));
      req.y = CoordW'($urandom_range(hot_h - 1));
    end else if (roll < 82 && width_in_use() != 0 && height_in_use() != 0) begin
      req.x = CoordW'($urandom_range(width_in_use() - 1));
      req.y = CoordW'($urandom_range(height_in_use() - 1));
    end else begin
      req.x = CoordW'($urandom_range(511));
      req.y = CoordW'($urandom_range(511));
    end
    case ($urandom_range(3))
      0, 1: req.depth = $urandom();
      // narrow band around zero gives ties
      2: req.depth = $urandom_range(16) - 8;
      default: begin
        case ($urandom_range(2))
          0: req.depth = 32'h8000_0000;
          1: req.depth = FAR_DEPTH;
          default: req.depth = FAR_DEPTH - 1;
        endcase
      end
    endcase
    if ($urandom_range(1)) begin
      req.red   = ChanW'($urandom_range(1023));
      req.green = ChanW'($urandom_range(1023));
      req.blue  = ChanW'($urandom_range(1023));
    end else begin
      req.red   = ChanW'($urandom_range(512) - 256);
      req.green = ChanW'($urandom_range(512) - 256);
      req.blue  = ChanW'($urandom_range(512) - 256);
    end
    return req;
  endfunction

  // result side: random stalls, or a long hold-off counted down here
  always @(posedge clk_i) begin
    if (ready_hold_left != 0) begin
      out_ready_i     <= 1'b0;
      ready_hold_left <= ready_hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    pixel_resp_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected output transaction, expected none, actual depth 0x%0h",
                 $time, depth_out_o);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("coord_valid", 32'(want.coord_valid), 32'(coord_valid_o));
        check_field("was_written", 32'(want.was_written), 32'(was_written_o));
        check_field("red_out", 32'(want.red), 32'(red_out_o));
        check_field("green_out", 32'(want.green), 32'(green_out_o));
        check_field("blue_out", 32'(want.blue), 32'(blue_out_o));
        check_field("depth_out", want.depth, depth_out_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, the strict less-than depth test, colour saturation,
  // out-of-frame coordinates and the spare mode
  task automatic test_item_corners();
    set_frame_size(256, 256);
    send_fields(MODE_READ, 0, 0, 0, 0, 0, 0);
    // equal to the cleared depth: not nearer, nothing stored
    send_fields(MODE_FRAG, 0, 0, FAR_DEPTH, 256, 256, 256);
    send_fields(MODE_FRAG, 0, 0, FAR_DEPTH - 1, 256, 256, 256);
    send_fields(MODE_FRAG, 0, 0, FAR_DEPTH - 1, 0, 0, 0);
    // most negative depth, green and blue at the ends of the 10-bit range
    send_fields(MODE_FRAG, 0, 0, 32'h8000_0000, -256, 511, -512);
    send_fields(MODE_FRAG, 0, 0, 32'h8000_0000, 100, 100, 100);
    // rounding right around the midpoint
    send_fields(MODE_FRAG, 255, 255, 100, -1, 1, 2);
    send_fields(MODE_FRAG, 255, 255, 99, 255, -255, 0);
    send_fields(MODE_FRAG, 256, 0, -1, 256, 256, 256);
    send_fields(MODE_FRAG, 0, 256, -1, 256, 256, 256);
    send_fields(MODE_READ, 511, 511, 32'hFFFF_FFFF, 511, 511, 511);
    send_fields(MODE_SPARE, 255, 255, -1000, 256, 256, 256);
    send_fields(MODE_READ, 255, 255, 0, 0, 0, 0);
  endtask

  // zero size, one pixel, and sizes beyond the store
  task automatic test_frame_limits();
    set_frame_size(0, 0);
    send_fields(MODE_READ, 0, 0, 0, 0, 0, 0);
    send_fields(MODE_FRAG, 0, 0, -5, 128, 128, 128);
    set_frame_size(1, 1);
    send_fields(MODE_FRAG, 0, 0, -5, 128, 64, 32);
    send_fields(MODE_READ, 1, 0, 0, 0, 0, 0);
    send_fields(MODE_READ, 0, 1, 0, 0, 0, 0);
    set_frame_size(511, 511);
    send_fields(MODE_READ, 255, 255, 0, 0, 0, 0);
    send_fields(MODE_FRAG, 256, 3, -9, 0, 0, 0);
  endtask

  // a clear wipes the whole store, pixels outside the small frame too
  task automatic test_clear_whole_store();
    set_frame_size(256, 256);
    send_fields(MODE_FRAG, 200, 100, 5, 200, 150, 100);
    set_frame_size(4, 4);
    send_fields(MODE_FRAG, 3, 0, 10, 50, 60, 70);
    send_fields(MODE_CLEAR, 3, 0, 0, 0, 0, 0);
    set_frame_size(256, 256);
    send_fields(MODE_READ, 200, 100, 0, 0, 0, 0);
    send_fields(MODE_READ, 3, 0, 0, 0, 0, 0);
  endtask

  task automatic run_traffic_phase(input int unsigned n_items, input int unsigned gap_pct,
                                   input int unsigned stall_pct, input int unsigned w,
                                   input int unsigned h);
    pixel_req_t  req;
    int unsigned clear_at;
    set_frame_size(w, h);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    // one clear per phase, since each sweeps the whole store
    clear_at = $urandom_range(n_items - 1);
    for (int unsigned i = 0; i < n_items; i++) begin
      req = random_pixel_req();
      if (i == clear_at) req.mode = MODE_CLEAR;
      send_pixel_req(req);
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(250, 0, 0, 256, 256);
    run_traffic_phase(250, 46, 0, 7, 5);
    run_traffic_phase(250, 0, 46, 300, 511);
    run_traffic_phase(250, 20, 20, 13, 1);
  endtask

  // result side held off long enough that the block fills and drops in_ready
  task automatic test_backpressure();
    set_frame_size(256, 256);
    send_gap_pct    = 0;
    recv_stall_pct  = 0;
    ready_hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      send_pixel_req(random_pixel_req());
    end
  endtask

  initial begin
    frame_w_reg = 32'(FRAME_DIM_RESET);
    frame_h_reg = 32'(FRAME_DIM_RESET);
    wipe_shadow();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the store sweeps itself clean after reset
    do @(posedge clk_i); while (in_ready_o !== 1'b1);

    test_item_corners();
    test_frame_limits();
    test_clear_whole_store();
    test_random_traffic();
    test_backpressure();

    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    // wait on briefly to catch any stray output transaction
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dtps_pkg.sv
sv/dtps_ctrl.sv
sv/dtps_datapath.sv
sv/depth_tested_pixel_store.sv
tb/depth_tested_pixel_store_tb.sv
